// File: rtl/race_time_sort_and_rank_top_assert.svh
// ----------------------------------------------------------------------------
// Race time sort and rank: assertion macros
// Implication checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RACE_TIME_SORT_AND_RANK_TOP_ASSERT_SVH
`define RACE_TIME_SORT_AND_RANK_TOP_ASSERT_SVH

// Same-cycle implication.
`define RTSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rtsr_pkg.sv
// ----------------------------------------------------------------------------
// Race time sort and rank: shared package
// Entry record, field widths and rank limit.
// ----------------------------------------------------------------------------
package rtsr_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int RANK_W = 5;

    localparam logic [RANK_W-1:0] RANK_FIRST = 5'd1;
    localparam logic [RANK_W-1:0] RANK_MAX   = 5'd31;

    typedef struct packed {
        logic [ID_W-1:0]   car_id;
        logic [TIME_W-1:0] ftime;
        logic              finished;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath
    typedef struct packed {
        logic store;      // write the input beat at the fill position
        logic rd_en;      // read the store at rd_addr
        logic load_held;  // take read data into the held entry
        logic swap;       // compare held with read data, exchange if held is later
        logic put_held;   // write the held entry at wr_addr
        logic emit;       // present read data as a result
        logic first;      // emitted result is the first of the run
        logic last;       // emitted result is the last of the run
        logic clr_count;  // empty the store for the next race
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic swap_need;  // held time is greater than read time
        logic single;     // exactly one entry stored
    } status_t;

endpackage

// File: rtl/race_time_sort_and_rank_top.sv
// An entry without last_entry leaves busy low, and the next
//   beat may follow at once. The last entry holds busy high through the sort passes
//   and the output run for n stored entries; results stream one per cycle.
// Throughput is set by the exchange pass, one compare per cycle on one store read port.
// Reset (rst_n low, asynchronous) empties the store and returns to idle; results
//   cannot be stalled.
// ----------------------------------------------------------------------------
// Race time sort and rank: top level
// Collects race entries, sorts them by finish time with an exchange sort
// and streams them out with a dense rank.
// ----------------------------------------------------------------------------
`include "race_time_sort_and_rank_top_assert.svh"

module race_time_sort_and_rank_top #(
    parameter int MAX_CARS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input beat: taken when start is high and busy is low
    input  logic                        start,
    output logic                        busy,
    input  logic [rtsr_pkg::ID_W-1:0]   car_id,
    input  logic [rtsr_pkg::TIME_W-1:0] finish_time,
    input  logic                        finished,
    input  logic                        last_entry,
    // Result beat: valid for the single cycle out_strobe is high
    output logic                        out_strobe,
    output logic [rtsr_pkg::ID_W-1:0]   out_car_id,
    output logic [rtsr_pkg::TIME_W-1:0] out_time,
    output logic                        out_finished,
    output logic [rtsr_pkg::RANK_W-1:0] rank,
    output logic                        last_result
);

    localparam int IDX_W = $clog2(MAX_CARS);
    localparam int CNT_W = $clog2(MAX_CARS + 1);

    rtsr_pkg::cmd_t    cmd;
    rtsr_pkg::status_t st;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  count;

    // Sequence load, sort passes (hold one entry, scan the rest), then the run.
    rtsr_ctrl #(
        .MAX_CARS (MAX_CARS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_entry (last_entry),
        .count      (count),
        .st         (st),
        .busy       (busy),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr)
    );

    // Store entries, compare and exchange, rank and register each result beat.
    rtsr_dp #(
        .MAX_CARS (MAX_CARS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .car_id       (car_id),
        .finish_time  (finish_time),
        .finished     (finished),
        .count        (count),
        .st           (st),
        .out_car_id   (out_car_id),
        .out_time     (out_time),
        .out_finished (out_finished),
        .rank         (rank),
        .last_result  (last_result),
        .out_strobe   (out_strobe)
    );

    // A run streams without gaps until its last beat.
    `RTSR_ASSERT_NEXT(a_run_unbroken, out_strobe && !last_result, out_strobe,
        "result run broke off before its last beat")
    // The last beat finds the block idle with an empty store.
    `RTSR_ASSERT_NOW(a_last_clears, out_strobe && last_result, !busy && count == '0,
        "store not cleared after the run")
    // A run opens at rank one.
    `RTSR_ASSERT_NOW(a_first_rank, out_strobe && !$past(out_strobe),
        rank == rtsr_pkg::RANK_FIRST, "run did not open at rank one")
    // The fill count never passes the store depth.
    `RTSR_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(MAX_CARS),
        "entry count beyond store depth")

endmodule

// File: rtl/rtsr_ram.sv
// ----------------------------------------------------------------------------
// Race time sort and rank: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rtsr_dp.sv
// ----------------------------------------------------------------------------
// Race time sort and rank: datapath
// Entry store, fill count, held entry for the exchange pass, rank and
// result registers.
// ----------------------------------------------------------------------------
module rtsr_dp #(
    parameter int MAX_CARS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rtsr_pkg::cmd_t                      cmd,
    input  logic [$clog2(MAX_CARS)-1:0]         rd_addr,
    input  logic [$clog2(MAX_CARS)-1:0]         wr_addr,
    input  logic [rtsr_pkg::ID_W-1:0]           car_id,
    input  logic [rtsr_pkg::TIME_W-1:0]         finish_time,
    input  logic                                finished,
    output logic [$clog2(MAX_CARS+1)-1:0]       count,
    output rtsr_pkg::status_t                   st,
    output logic [rtsr_pkg::ID_W-1:0]           out_car_id,
    output logic [rtsr_pkg::TIME_W-1:0]         out_time,
    output logic                                out_finished,
    output logic [rtsr_pkg::RANK_W-1:0]         rank,
    output logic                                last_result,
    output logic                                out_strobe
);

    localparam int IDX_W = $clog2(MAX_CARS);
    localparam int CNT_W = $clog2(MAX_CARS + 1);

    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       full;
    rtsr_pkg::entry_t           held_reg;
    rtsr_pkg::entry_t           in_entry;
    rtsr_pkg::entry_t           wr_entry;
    rtsr_pkg::entry_t           rd_entry;
    logic [rtsr_pkg::ENTRY_W-1:0] rd_raw;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_sel;
    logic [rtsr_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic [rtsr_pkg::TIME_W-1:0] prev_time_reg;
    rtsr_pkg::entry_t           res_reg;
    logic                       last_reg;
    logic                       strobe_reg;

    assign full     = (count_reg == CNT_W'(MAX_CARS));
    assign in_entry = '{car_id: car_id, ftime: finish_time, finished: finished};
    assign rd_entry = rtsr_pkg::entry_t'(rd_raw);

    assign st.swap_need = (held_reg.ftime > rd_entry.ftime);
    assign st.single    = (count_reg == CNT_W'(1));

    // Drop a beat that arrives with the store full.
    always_comb
    begin
        wr_en    = (cmd.store && !full) || (cmd.swap && st.swap_need) || cmd.put_held;
        wr_sel   = cmd.store ? count_reg[IDX_W-1:0] : wr_addr;
        wr_entry = cmd.store ? in_entry : held_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.store && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= cmd.emit;
        end
    end

    rtsr_ram #(
        .WIDTH (rtsr_pkg::ENTRY_W),
        .DEPTH (MAX_CARS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_sel),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Dense rank: advance on each new distinct time, saturate at the ceiling.
    always_comb
    begin
        if (cmd.first)
        begin
            rank_next = rtsr_pkg::RANK_FIRST;
        end
        else if (rd_entry.ftime != prev_time_reg && rank_reg != rtsr_pkg::RANK_MAX)
        begin
            rank_next = rank_reg + rtsr_pkg::RANK_W'(1);
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_held || (cmd.swap && st.swap_need))
        begin
            held_reg <= rd_entry;
        end
        if (cmd.emit)
        begin
            rank_reg      <= rank_next;
            prev_time_reg <= rd_entry.ftime;
            res_reg       <= rd_entry;
            last_reg      <= cmd.last;
        end
    end

    assign count        = count_reg;
    assign out_car_id   = res_reg.car_id;
    assign out_time     = res_reg.ftime;
    assign out_finished = res_reg.finished;
    assign rank         = rank_reg;
    assign last_result  = last_reg;
    assign out_strobe   = strobe_reg;

endmodule

// File: rtl/rtsr_ctrl.sv
// ----------------------------------------------------------------------------
// Race time sort and rank: controller
// Sequences loading, the exchange sort passes and the output run.
// ----------------------------------------------------------------------------
module rtsr_ctrl #(
    parameter int MAX_CARS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          last_entry,
    input  logic [$clog2(MAX_CARS+1)-1:0] count,
    input  rtsr_pkg::status_t             st,
    output logic                          busy,
    output rtsr_pkg::cmd_t                cmd,
    output logic [$clog2(MAX_CARS)-1:0]   rd_addr,
    output logic [$clog2(MAX_CARS)-1:0]   wr_addr
);

    localparam int IDX_W = $clog2(MAX_CARS);
    localparam int CNT_W = $clog2(MAX_CARS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_PISS  = 3'd2;
    localparam logic [2:0] S_PLD   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_PWR   = 3'd5;
    localparam logic [2:0] S_ORD   = 3'd6;
    localparam logic [2:0] S_OEM   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] q_reg, q_next;
    logic             q_end;
    logic             p_end;

    assign q_end = (CNT_W'(q_reg) == count - CNT_W'(1));
    assign p_end = (CNT_W'(p_reg) == count - CNT_W'(2));

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        cmd        = '0;
        rd_addr    = q_reg;
        wr_addr    = q_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.store = 1'b1;
                    if (last_entry)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                p_next = '0;
                q_next = '0;
                state_next = st.single ? S_ORD : S_PISS;
            end
            S_PISS:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = p_reg;
                q_next     = p_reg + IDX_W'(1);
                state_next = S_PLD;
            end
            S_PLD:
            begin
                cmd.load_held = 1'b1;
                cmd.rd_en     = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.swap = 1'b1;
                if (q_end)
                begin
                    state_next = S_PWR;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = q_reg + IDX_W'(1);
                    q_next    = q_reg + IDX_W'(1);
                end
            end
            S_PWR:
            begin
                cmd.put_held = 1'b1;
                wr_addr      = p_reg;
                if (p_end)
                begin
                    q_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    p_next     = p_reg + IDX_W'(1);
                    state_next = S_PISS;
                end
            end
            S_ORD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_OEM;
            end
            S_OEM:
            begin
                cmd.emit  = 1'b1;
                cmd.first = (q_reg == '0);
                cmd.last  = q_end;
                if (q_end)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = q_reg + IDX_W'(1);
                    q_next    = q_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= '0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: test/tb_race_time_sort_and_rank_top.sv
// ----------------------------------------------------------------------------
// Race time sort and rank: testbench
// Feeds races of entries through the start/busy handshake. A directed table
// comes first, then random races. Each finished race is sorted and ranked by
// a local predictor unless its result is typed in, and every result strobe is checked against that.
// ----------------------------------------------------------------------------
module tb_race_time_sort_and_rank_top;

    localparam int MAX_CARS    = 16;
    localparam int RAND_ITEMS  = 155;
    localparam int DRAIN_WAIT  = 200;
    localparam int PRINT_LIMIT = 40;

    // One sorted position as it leaves the block
    typedef struct packed {
        logic [rtsr_pkg::ID_W-1:0]   car_id;
        logic [rtsr_pkg::TIME_W-1:0] ftime;
        logic                        finished;
        logic [rtsr_pkg::RANK_W-1:0] rank;
        logic                        last;
    } standing_t;

    // One input beat, with an optional hand-typed expectation
    typedef struct packed {
        rtsr_pkg::entry_t ent;
        logic             last;
        logic             typed;
        standing_t        exp;
    } race_beat_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start;
    logic                        busy;
    logic [rtsr_pkg::ID_W-1:0]   car_id;
    logic [rtsr_pkg::TIME_W-1:0] finish_time;
    logic                        finished;
    logic                        last_entry;
    logic                        out_strobe;
    logic [rtsr_pkg::ID_W-1:0]   out_car_id;
    logic [rtsr_pkg::TIME_W-1:0] out_time;
    logic                        out_finished;
    logic [rtsr_pkg::RANK_W-1:0] rank;
    logic                        last_result;

    race_beat_t race_feed [$];
    standing_t  standings_q [$];

    // Predictor copy of the entry store
    rtsr_pkg::entry_t grid [$];
    int               mismatches = 0;

    race_time_sort_and_rank_top #(
        .MAX_CARS(MAX_CARS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .car_id(car_id),
        .finish_time(finish_time),
        .finished(finished),
        .last_entry(last_entry),
        .out_strobe(out_strobe),
        .out_car_id(out_car_id),
        .out_time(out_time),
        .out_finished(out_finished),
        .rank(rank),
        .last_result(last_result)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one
    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            if (mismatches < PRINT_LIMIT)
            begin
                $display("mismatch %s: got %0h expected %0h", what, got, want);
            end
            mismatches++;
        end
    endtask

    // Append one row to the stimulus; typed rows carry their expected result
    task add_row(input logic [rtsr_pkg::ID_W-1:0] id, input logic [rtsr_pkg::TIME_W-1:0] t,
                 input logic fin, input logic lst, input logic typed,
                 input logic [rtsr_pkg::ID_W-1:0] e_id,
                 input logic [rtsr_pkg::TIME_W-1:0] e_time, input logic e_fin,
                 input logic [rtsr_pkg::RANK_W-1:0] e_rank, input logic e_last);
        race_beat_t b;
        begin
            b.ent.car_id   = id;
            b.ent.ftime    = t;
            b.ent.finished = fin;
            b.last         = lst;
            b.typed        = typed;
            b.exp.car_id   = e_id;
            b.exp.ftime    = e_time;
            b.exp.finished = e_fin;
            b.exp.rank     = e_rank;
            b.exp.last     = e_last;
            race_feed.push_back(b);
        end
    endtask

    // Store an accepted entry; on the last entry sort, rank and queue the standings
    task rank_entry(input race_beat_t b);
        int               n;
        int               p;
        int               q;
        int               k;
        int               cur_rank;
        rtsr_pkg::entry_t tmp;
        standing_t        s;
        begin
            // Drop the entry when the store is full
            if (grid.size() < MAX_CARS)
            begin
                grid.push_back(b.ent);
            end
            if (b.last)
            begin
                n = grid.size();
                // Exchange sort over every pair p < q; this fixes the order of ties
                for (p = 0; p + 1 < n; p++)
                begin
                    for (q = p + 1; q < n; q++)
                    begin
                        if (grid[p].ftime > grid[q].ftime)
                        begin
                            tmp     = grid[p];
                            grid[p] = grid[q];
                            grid[q] = tmp;
                        end
                    end
                end
                cur_rank = int'(rtsr_pkg::RANK_FIRST);
                for (k = 0; k < n; k++)
                begin
                    s.car_id   = grid[k].car_id;
                    s.ftime    = grid[k].ftime;
                    s.finished = grid[k].finished;
                    s.rank     = cur_rank[rtsr_pkg::RANK_W-1:0];
                    s.last     = (k + 1 == n);
                    standings_q.push_back(b.typed ? b.exp : s);
                    // Dense rank: advance only on a new distinct time, hold at the ceiling
                    if (k + 1 < n && grid[k].ftime != grid[k + 1].ftime
                        && cur_rank < int'(rtsr_pkg::RANK_MAX))
                    begin
                        cur_rank++;
                    end
                end
                grid.delete();
            end
        end
    endtask

    // Result monitor: the receiver never stalls, so check every strobe at the edge
    always @(posedge clk)
    begin
        standing_t w;
        if (rst_n && out_strobe)
        begin
            if (standings_q.size() == 0)
            begin
                report_mismatch("unexpected result, car", 32'(out_car_id), 32'h0);
            end
            else
            begin
                w = standings_q.pop_front();
                if (out_car_id !== w.car_id)
                begin
                    report_mismatch("car_id", 32'(out_car_id), 32'(w.car_id));
                end
                if (out_time !== w.ftime)
                begin
                    report_mismatch("time", out_time, w.ftime);
                end
                if (out_finished !== w.finished)
                begin
                    report_mismatch("finished", 32'(out_finished), 32'(w.finished));
                end
                if (rank !== w.rank)
                begin
                    report_mismatch("rank", 32'(rank), 32'(w.rank));
                end
                if (last_result !== w.last)
                begin
                    report_mismatch("last_result", 32'(last_result), 32'(w.last));
                end
            end
        end
    end

    // Stimulus, sender and end of run
    initial
    begin
        int         idx;
        int         made;
        int         n;
        int         k;
        int         mode;
        int         burst_left;
        int         gap_left;
        race_beat_t b;

        // Hold all inputs at known values from time zero
        start       <= 1'b0;
        car_id      <= '0;
        finish_time <= '0;
        finished    <= 1'b0;
        last_entry  <= 1'b0;

        // Directed table. Single-entry races right after reset and at the field
        // extremes have their result typed in; the rest go through the predictor.
        add_row(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 5'd1, 1'b1);
        add_row(8'h00, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 8'h00, 32'h0000_0000, 1'b0, 5'd1, 1'b1);
        // Short race, out of order, with a tie at the slower time
        add_row(8'h10, 32'h0001_2C00, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h11, 32'h0000_6400, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h12, 32'h0001_2C00, 1'b0, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        // Two cars dead level
        add_row(8'h20, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h21, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        // Full grid, then two entries past capacity; the last dropped one carries last_entry
        add_row(8'h30, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h31, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h32, 32'h0005_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h33, 32'h0005_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h34, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h35, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h36, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h37, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h38, 32'h0012_3456, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h39, 32'h0005_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3A, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3B, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3C, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3D, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3E, 32'h0100_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h3F, 32'h00FF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h40, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);
        add_row(8'h41, 32'h1234_5678, 1'b0, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0, 5'd0, 1'b0);

        // Random races: mostly well-formed, about one in ten overfills the grid.
        made = 0;
        while (made < RAND_ITEMS)
        begin
            n    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(MAX_CARS + 1, MAX_CARS + 4))
                                               : int'($urandom_range(1, MAX_CARS));
            mode = int'($urandom_range(0, 3));
            for (k = 0; k < n; k++)
            begin
                b.ent.car_id   = rtsr_pkg::ID_W'($urandom);
                b.ent.finished = 1'($urandom_range(0, 1));
                case (mode)
                    0: b.ent.ftime = $urandom;
                    // Few distinct values: heavy ties
                    1: b.ent.ftime = $urandom_range(0, 3) << 16;
                    // Extremes and near-extremes
                    2: b.ent.ftime = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                     : 32'hFFFF_FFFF - $urandom_range(0, 2);
                    default: b.ent.ftime = {4'($urandom_range(0, 15)), 28'h0}
                                           | $urandom_range(0, 1);
                endcase
                b.last  = (k == n - 1);
                b.typed = 1'b0;
                b.exp   = '0;
                race_feed.push_back(b);
                made++;
            end
        end

        // Hold reset, then release it at an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx        = 0;
        burst_left = 1;
        gap_left   = 0;
        while (idx < race_feed.size())
        begin
            @(posedge clk);
            // A beat is taken at this edge when start was high and busy low
            if (start && !busy)
            begin
                rank_entry(race_feed[idx]);
                idx++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // One burst in four runs long with no gap after it
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = int'($urandom_range(10, 40));
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = int'($urandom_range(1, 12));
                        gap_left   = int'($urandom_range(1, 8));
                    end
                end
            end
            if (idx < race_feed.size() && gap_left == 0)
            begin
                start       <= 1'b1;
                car_id      <= race_feed[idx].ent.car_id;
                finish_time <= race_feed[idx].ent.ftime;
                finished    <= race_feed[idx].ent.finished;
                last_entry  <= race_feed[idx].last;
            end
            else
            begin
                // Idle: drop start and scramble the data, which must be ignored
                start       <= 1'b0;
                car_id      <= rtsr_pkg::ID_W'($urandom);
                finish_time <= $urandom;
                finished    <= 1'($urandom_range(0, 1));
                last_entry  <= 1'($urandom_range(0, 1));
                if (gap_left > 0)
                begin
                    gap_left--;
                end
            end
        end

        // Drain: wait for every standing, then a little longer for strays
        while (standings_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
